FILE: hw/rtl/usv_pkg.sv
// shared types and constants of the uri syntax validator
`default_nettype none

package usv_pkg;

    // one input byte and its end marker
    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } t_in_item;

    // verdict for one uri
    typedef struct packed {
        logic uri_valid;
        logic bracketed_host;
    } t_out_item;

    // byte class flags produced by the front end
    typedef struct packed {
        logic       last_byte;
        logic       is_hex;
        logic       is_scheme;
        logic       is_host_ch;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_colon;
        logic       is_slash;
        logic       is_qmark;
        logic       is_hash;
        logic       is_at;
        logic       is_pct;
        logic       is_lbrack;
        logic       is_rbrack;
    } t_byte_class;

    // parse phase
    typedef enum logic [2:0] {
        PH_SCHEME = 3'd0,
        PH_COLON  = 3'd1,
        PH_SLASH  = 3'd2,
        PH_HOST   = 3'd3,
        PH_PATH   = 3'd4,
        PH_QUERY  = 3'd5,
        PH_FRAG   = 3'd6,
        PH_FAIL   = 3'd7
    } t_phase;

    // host and port tracking
    typedef struct packed {
        logic        clean;
        logic        colon_seen;
        logic        tail_digits;
        logic        tail_clean;
        logic [16:0] port_value;
        logic        opens_bracket;
        logic        last_close;
        logic        close_before_colon;
        logic        started;
    } t_host_st;

    localparam logic [16:0] PORT_SAT         = 17'd65536;
    localparam logic [15:0] PORT_LIMIT_RESET = 16'd65535;
    localparam logic [1:0]  ESC_DIGITS       = 2'd2;

    localparam t_host_st HOST_RESET = '{
        clean:              1'b1,
        colon_seen:         1'b0,
        tail_digits:        1'b1,
        tail_clean:         1'b1,
        port_value:         17'd0,
        opens_bracket:      1'b0,
        last_close:         1'b0,
        close_before_colon: 1'b0,
        started:            1'b0
    };

endpackage

`default_nettype wire

FILE: hw/rtl/usv_front.sv
// front end: input handshake and byte classification
`default_nettype none

module usv_front (
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire usv_pkg::t_in_item    i_in_data,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output usv_pkg::t_byte_class      o_push_cls
);

    logic [7:0] b;
    logic       alnum;
    logic       digit;

    assign b     = i_in_data.char_byte;
    assign digit = (b >= 8'h30) && (b <= 8'h39);
    assign alnum = digit || ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));

    // accept whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // class lookup
    always_comb begin
        o_push_cls.last_byte = i_in_data.last_byte;
        o_push_cls.is_digit  = digit;
        o_push_cls.digit     = b[3:0];
        o_push_cls.is_hex    = digit || ((b >= 8'h41) && (b <= 8'h46))
                                     || ((b >= 8'h61) && (b <= 8'h66));
        o_push_cls.is_scheme = alnum || (b == 8'h2b) || (b == 8'h2d) || (b == 8'h2e);
        // unreserved and sub-delims
        o_push_cls.is_host_ch = alnum || (b == 8'h2d) || (b == 8'h2e) || (b == 8'h5f)
                             || (b == 8'h7e) || (b == 8'h21) || (b == 8'h24)
                             || (b == 8'h26) || (b == 8'h27) || (b == 8'h28)
                             || (b == 8'h29) || (b == 8'h2a) || (b == 8'h2b)
                             || (b == 8'h2c) || (b == 8'h3b) || (b == 8'h3d);
        o_push_cls.is_colon  = (b == 8'h3a);
        o_push_cls.is_slash  = (b == 8'h2f);
        o_push_cls.is_qmark  = (b == 8'h3f);
        o_push_cls.is_hash   = (b == 8'h23);
        o_push_cls.is_at     = (b == 8'h40);
        o_push_cls.is_pct    = (b == 8'h25);
        o_push_cls.is_lbrack = (b == 8'h5b);
        o_push_cls.is_rbrack = (b == 8'h5d);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/usv_queue.sv
// short queue of classified bytes between front and back end
`default_nettype none

module usv_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire usv_pkg::t_byte_class  i_push_cls,
    output logic                       o_full,
    output logic                       o_valid,
    output usv_pkg::t_byte_class       o_head,
    input  wire logic                  i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    usv_pkg::t_byte_class r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cls;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/usv_parser.sv
// back end: uri parse state, port limit register and verdict output register
`default_nettype none

module usv_parser (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [15:0]           i_cfg_data,
    input  wire logic                  i_head_valid,
    input  wire usv_pkg::t_byte_class  i_head,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output usv_pkg::t_out_item         o_out_data
);

    logic [15:0]       r_port_limit;
    usv_pkg::t_phase   r_phase;
    usv_pkg::t_phase   n_phase;
    logic              r_scheme_ne;
    logic              n_scheme_ne;
    logic [1:0]        r_esc;
    logic [1:0]        n_esc;
    logic              r_ui_ok;
    logic              n_ui_ok;
    logic              r_after_at;
    logic              n_after_at;
    usv_pkg::t_host_st r_host;
    usv_pkg::t_host_st n_host;
    logic              r_out_valid;
    usv_pkg::t_out_item r_out_data;
    usv_pkg::t_out_item n_verdict;

    // host and port check
    function automatic logic host_ok(input usv_pkg::t_host_st h, input logic [15:0] lim);
        logic body;
        logic ends;
        logic over;
        over = h.port_value > {1'b0, lim};
        if (h.colon_seen && h.tail_digits) begin
            body = h.clean && !over;
            ends = h.close_before_colon && !over;
        end else begin
            body = !h.colon_seen && h.tail_clean;
            ends = h.last_close;
        end
        return h.opens_bracket ? ends : body;
    endfunction

    // one ordinary host byte
    function automatic usv_pkg::t_host_st host_byte(input usv_pkg::t_host_st h,
                                                    input usv_pkg::t_byte_class c);
        usv_pkg::t_host_st r;
        logic [19:0]       p;
        logic [19:0]       prod;
        r = h;
        p = {3'b000, h.port_value};
        prod = (p << 3) + (p << 1) + {16'd0, c.digit};
        if (!h.started) begin
            r.opens_bracket = c.is_lbrack;
            r.started       = 1'b1;
        end
        if (c.is_colon) begin
            r.clean              = h.clean && h.tail_clean && !h.colon_seen;
            r.close_before_colon = h.last_close;
            r.colon_seen         = 1'b1;
            r.tail_digits        = 1'b1;
            r.tail_clean         = 1'b1;
            r.port_value         = '0;
        end else begin
            r.tail_clean = h.tail_clean && c.is_host_ch;
            if (c.is_digit) begin
                r.port_value = (prod > {3'b000, usv_pkg::PORT_SAT}) ?
                               usv_pkg::PORT_SAT : prod[16:0];
            end else begin
                r.tail_digits = 1'b0;
            end
        end
        r.last_close = c.is_rbrack;
        return r;
    endfunction

    // path, query and fragment bytes
    function automatic usv_pkg::t_phase seg_phase(input usv_pkg::t_phase ph,
                                                  input usv_pkg::t_byte_class c);
        usv_pkg::t_phase r;
        if (c.is_pct) begin
            r = ph;
        end else if (ph == usv_pkg::PH_PATH && c.is_qmark) begin
            r = usv_pkg::PH_QUERY;
        end else if ((ph == usv_pkg::PH_PATH || ph == usv_pkg::PH_QUERY) && c.is_hash) begin
            r = usv_pkg::PH_FRAG;
        end else if (c.is_host_ch || c.is_colon || c.is_at || c.is_slash
                     || (ph != usv_pkg::PH_PATH && c.is_qmark)) begin
            r = ph;
        end else begin
            r = usv_pkg::PH_FAIL;
        end
        return r;
    endfunction

    // a last byte waits for a free output slot, other bytes never wait
    assign o_pop       = i_head_valid && (!i_head.last_byte || !r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // next parse state for the byte at the queue head
    always_comb begin
        n_phase     = r_phase;
        n_scheme_ne = r_scheme_ne;
        n_esc       = r_esc;
        n_ui_ok     = r_ui_ok;
        n_after_at  = r_after_at;
        n_host      = r_host;
        if (r_phase != usv_pkg::PH_FAIL) begin
            if (r_esc != 2'd0) begin
                if (i_head.is_hex) begin
                    n_esc = r_esc - 2'd1;
                end else begin
                    n_phase = usv_pkg::PH_FAIL;
                end
            end else begin
                case (r_phase)
                    usv_pkg::PH_SCHEME: begin
                        if (i_head.is_colon) begin
                            n_phase = r_scheme_ne ? usv_pkg::PH_COLON : usv_pkg::PH_FAIL;
                        end else if (i_head.is_scheme) begin
                            n_scheme_ne = 1'b1;
                        end else begin
                            n_phase = usv_pkg::PH_FAIL;
                        end
                    end
                    usv_pkg::PH_COLON: begin
                        if (i_head.is_slash) begin
                            n_phase = usv_pkg::PH_SLASH;
                        end else begin
                            n_phase = seg_phase(usv_pkg::PH_PATH, i_head);
                            if (i_head.is_pct) n_esc = usv_pkg::ESC_DIGITS;
                        end
                    end
                    usv_pkg::PH_SLASH: begin
                        if (i_head.is_slash) begin
                            n_phase    = usv_pkg::PH_HOST;
                            n_after_at = 1'b0;
                            n_ui_ok    = 1'b1;
                            n_host     = usv_pkg::HOST_RESET;
                        end else begin
                            n_phase = seg_phase(usv_pkg::PH_PATH, i_head);
                            if (i_head.is_pct) n_esc = usv_pkg::ESC_DIGITS;
                        end
                    end
                    usv_pkg::PH_HOST: begin
                        if (i_head.is_pct) begin
                            n_esc = usv_pkg::ESC_DIGITS;
                        end else if (i_head.is_slash || i_head.is_qmark || i_head.is_hash) begin
                            if (!host_ok(r_host, r_port_limit)) begin
                                n_phase = usv_pkg::PH_FAIL;
                            end else if (i_head.is_slash) begin
                                n_phase = usv_pkg::PH_PATH;
                            end else if (i_head.is_qmark) begin
                                n_phase = usv_pkg::PH_QUERY;
                            end else begin
                                n_phase = usv_pkg::PH_FRAG;
                            end
                        end else if (i_head.is_at && !r_after_at) begin
                            if (!r_ui_ok) begin
                                n_phase = usv_pkg::PH_FAIL;
                            end else begin
                                n_after_at = 1'b1;
                                n_host     = usv_pkg::HOST_RESET;
                            end
                        end else begin
                            if (!r_after_at) begin
                                n_ui_ok = r_ui_ok && (i_head.is_host_ch || i_head.is_colon);
                            end
                            n_host = host_byte(r_host, i_head);
                        end
                    end
                    default: begin
                        n_phase = seg_phase(r_phase, i_head);
                        if (i_head.is_pct) n_esc = usv_pkg::ESC_DIGITS;
                    end
                endcase
            end
        end
        // verdict from the state after this byte
        n_verdict.uri_valid = (n_phase != usv_pkg::PH_FAIL) && (n_phase != usv_pkg::PH_SCHEME)
                           && (n_esc == 2'd0)
                           && ((n_phase != usv_pkg::PH_HOST) || host_ok(n_host, r_port_limit));
        n_verdict.bracketed_host = n_verdict.uri_valid && n_host.opens_bracket;
    end

    // parse state, cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= usv_pkg::PH_SCHEME;
            r_scheme_ne <= 1'b0;
            r_esc       <= 2'd0;
            r_ui_ok     <= 1'b1;
            r_after_at  <= 1'b0;
            r_host      <= usv_pkg::HOST_RESET;
        end else if (o_pop) begin
            if (i_head.last_byte) begin
                r_phase     <= usv_pkg::PH_SCHEME;
                r_scheme_ne <= 1'b0;
                r_esc       <= 2'd0;
                r_ui_ok     <= 1'b1;
                r_after_at  <= 1'b0;
                r_host      <= usv_pkg::HOST_RESET;
            end else begin
                r_phase     <= n_phase;
                r_scheme_ne <= n_scheme_ne;
                r_esc       <= n_esc;
                r_ui_ok     <= n_ui_ok;
                r_after_at  <= n_after_at;
                r_host      <= n_host;
            end
        end
    end

    // port limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_limit <= usv_pkg::PORT_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_port_limit <= i_cfg_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last_byte) begin
            r_out_data <= n_verdict;
        end
    end

`ifndef NO_ASSERTIONS
    a_esc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc != 2'd3)
        else $error("escape counter out of range");
    a_port_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_host.port_value <= usv_pkg::PORT_SAT)
        else $error("port accumulator passed saturation");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.last_byte) |=>
            (r_phase == usv_pkg::PH_SCHEME && r_esc == 2'd0 && !r_scheme_ne))
        else $error("parse state not cleared after last byte");
    a_bracket_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_data.bracketed_host || r_out_data.uri_valid))
        else $error("bracket flag on an invalid uri");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/uri_syntax_validator_unit.sv
// top level of the uri syntax validator
//
// Checks one uri, fed as a stream of bytes, against uri syntax rules.
// Input channel (i_in_valid / o_in_ready / i_in_data): one byte per transfer,
// with last_byte set on the final byte of a uri. Output channel
// (o_out_valid / i_out_ready / o_out_data): one verdict per uri, uri_valid
// and bracketed_host, delivered after the transfer of its last byte.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the port
// limit; always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. Throughput: one byte per cycle
// while the queue has room. A byte is classified and written into a
// QUEUE_DEPTH-entry queue; the parse unit takes it from the queue head and
// registers the verdict of a last byte in the output register that drives
// o_out_valid. The parse unit handles one byte per cycle unless a last byte waits for a stalled output.
// A stalled output stalls only last bytes; the queue absorbs the rest, and
// o_in_ready drops only when the queue is full.
// Reset (synchronous, active low) empties queue and output, restarts the
// parse and sets the port limit to 65535.
`default_nettype none

module uri_syntax_validator_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire usv_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output usv_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [15:0]        i_cfg_data
);

    logic                 q_full;
    logic                 push;
    usv_pkg::t_byte_class push_cls;
    logic                 head_valid;
    usv_pkg::t_byte_class head;
    logic                 pop;

    assign o_cfg_ready = 1'b1;

    // classify
    usv_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_cls (push_cls)
    );

    // decoupling queue
    usv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cls (push_cls),
        .o_full     (q_full),
        .o_valid    (head_valid),
        .o_head     (head),
        .i_pop      (pop)
    );

    // parse and verdict
    usv_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// testbench for the uri syntax validator: streams uris byte by byte and checks every verdict
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYCLES = 12;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_BYTES = 1040;
    localparam int          PORT_CEIL    = 65536;
    localparam logic [15:0] LIMIT_MAX    = 16'd65535;
    localparam logic [15:0] LIMIT_MIN    = 16'd0;

    localparam string ALNUM_SET    =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    localparam string SCHEME_SET   = {ALNUM_SET, "+-."};
    localparam string HOST_SET     = {ALNUM_SET, "-._~!$&'()*+,;="};
    localparam string USERINFO_SET = {HOST_SET, ":"};
    localparam string SEGMENT_SET  = {HOST_SET, ":@/"};
    localparam string HEX_SET      = "0123456789abcdefABCDEF";
    localparam string IPV6_SET     = "0123456789abcdef:.";

    typedef logic [7:0] t_text[$];

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    usv_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    usv_pkg::t_out_item o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_data = '0;

    // parse state of the expected-verdict predictor
    usv_pkg::t_phase   uri_phase;
    logic              scheme_seen;
    logic [1:0]        esc_left;
    logic              userinfo_ok;
    logic              past_userinfo;
    usv_pkg::t_host_st host_st;
    logic [15:0]       port_limit;

    usv_pkg::t_out_item expected_verdicts[$];
    t_text              uri_buf;
    logic               quiet_mode = 1'b0;
    int                 error_count = 0;
    int                 cycle_count = 0;

    uri_syntax_validator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        i_out_ready <= quiet_mode || ($urandom_range(99) >= 9);
    end

    // character classes
    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return is_digit(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function automatic logic is_scheme_char(input logic [7:0] b);
        return is_alnum(b) || b == "+" || b == "-" || b == ".";
    endfunction

    // unreserved or sub-delims
    function automatic logic is_host_char(input logic [7:0] b);
        return is_alnum(b) || b == "-" || b == "." || b == "_" || b == "~" ||
               b == "!" || b == "$" || b == "&" || b == "'" || b == "(" ||
               b == ")" || b == "*" || b == "+" || b == "," || b == ";" || b == "=";
    endfunction

    function automatic logic is_pchar(input logic [7:0] b);
        return is_host_char(b) || b == ":" || b == "@";
    endfunction

    function automatic void host_clear();
        host_st.clean              = 1'b1;
        host_st.colon_seen         = 1'b0;
        host_st.tail_digits        = 1'b1;
        host_st.tail_clean         = 1'b1;
        host_st.port_value         = '0;
        host_st.opens_bracket      = 1'b0;
        host_st.last_close         = 1'b0;
        host_st.close_before_colon = 1'b0;
        host_st.started            = 1'b0;
    endfunction

    function automatic void uri_clear();
        uri_phase     = usv_pkg::PH_SCHEME;
        scheme_seen   = 1'b0;
        esc_left      = '0;
        userinfo_ok   = 1'b1;
        past_userinfo = 1'b0;
        host_clear();
    endfunction

    // host verdict, with the port checked against the limit
    function automatic logic host_acceptable();
        logic body;
        logic ends;
        if (host_st.colon_seen && host_st.tail_digits) begin
            if (host_st.port_value > {1'b0, port_limit})
                return 1'b0;
            body = host_st.clean;
            ends = host_st.close_before_colon;
        end else begin
            body = !host_st.colon_seen && host_st.tail_clean;
            ends = host_st.last_close;
        end
        return host_st.opens_bracket ? ends : body;
    endfunction

    function automatic void host_char_step(input logic [7:0] b);
        int acc;
        if (!host_st.started) begin
            host_st.opens_bracket = (b == "[");
            host_st.started       = 1'b1;
        end
        if (!past_userinfo)
            userinfo_ok = userinfo_ok && (is_host_char(b) || b == ":");
        if (b == ":") begin
            host_st.clean              = host_st.clean && host_st.tail_clean &&
                                         !host_st.colon_seen;
            host_st.close_before_colon = host_st.last_close;
            host_st.colon_seen         = 1'b1;
            host_st.tail_digits        = 1'b1;
            host_st.tail_clean         = 1'b1;
            host_st.port_value         = '0;
        end else begin
            host_st.tail_clean = host_st.tail_clean && is_host_char(b);
            if (is_digit(b)) begin
                // accumulator saturates just past every possible limit
                acc = int'(host_st.port_value) * 10 + int'(b - "0");
                host_st.port_value = (acc > PORT_CEIL) ? 17'(PORT_CEIL) : 17'(acc);
            end else begin
                host_st.tail_digits = 1'b0;
            end
        end
        host_st.last_close = (b == "]");
    endfunction

    // path, query and fragment bytes
    function automatic void segment_step(input logic [7:0] b);
        if (b == "%") begin
            esc_left = 2'd2;
            return;
        end
        if (uri_phase == usv_pkg::PH_PATH && b == "?") begin
            uri_phase = usv_pkg::PH_QUERY;
            return;
        end
        if ((uri_phase == usv_pkg::PH_PATH || uri_phase == usv_pkg::PH_QUERY) && b == "#") begin
            uri_phase = usv_pkg::PH_FRAG;
            return;
        end
        if (is_pchar(b) || b == "/" || (uri_phase != usv_pkg::PH_PATH && b == "?"))
            return;
        uri_phase = usv_pkg::PH_FAIL;
    endfunction

    function automatic void parse_step(input logic [7:0] b);
        if (uri_phase == usv_pkg::PH_FAIL)
            return;
        // escape digits
        if (esc_left != 0) begin
            if (is_hex(b))
                esc_left = esc_left - 2'd1;
            else
                uri_phase = usv_pkg::PH_FAIL;
            return;
        end
        case (uri_phase)
            usv_pkg::PH_SCHEME: begin
                if (b == ":") begin
                    if (scheme_seen)
                        uri_phase = usv_pkg::PH_COLON;
                    else
                        uri_phase = usv_pkg::PH_FAIL;
                end else if (is_scheme_char(b)) begin
                    scheme_seen = 1'b1;
                end else begin
                    uri_phase = usv_pkg::PH_FAIL;
                end
            end
            usv_pkg::PH_COLON: begin
                if (b == "/") begin
                    uri_phase = usv_pkg::PH_SLASH;
                end else begin
                    uri_phase = usv_pkg::PH_PATH;
                    segment_step(b);
                end
            end
            usv_pkg::PH_SLASH: begin
                if (b == "/") begin
                    uri_phase     = usv_pkg::PH_HOST;
                    past_userinfo = 1'b0;
                    userinfo_ok   = 1'b1;
                    host_clear();
                end else begin
                    uri_phase = usv_pkg::PH_PATH;
                    segment_step(b);
                end
            end
            usv_pkg::PH_HOST: begin
                if (b == "%") begin
                    esc_left = 2'd2;
                end else if (b == "/" || b == "?" || b == "#") begin
                    if (!host_acceptable())
                        uri_phase = usv_pkg::PH_FAIL;
                    else if (b == "/")
                        uri_phase = usv_pkg::PH_PATH;
                    else if (b == "?")
                        uri_phase = usv_pkg::PH_QUERY;
                    else
                        uri_phase = usv_pkg::PH_FRAG;
                end else if (b == "@" && !past_userinfo) begin
                    if (!userinfo_ok) begin
                        uri_phase = usv_pkg::PH_FAIL;
                    end else begin
                        past_userinfo = 1'b1;
                        host_clear();
                    end
                end else begin
                    host_char_step(b);
                end
            end
            default: segment_step(b);
        endcase
    endfunction

    // advance the predictor by one accepted byte; the last byte yields a verdict
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        usv_pkg::t_out_item verdict;
        logic               ok;
        parse_step(b);
        if (!last)
            return;
        ok = uri_phase != usv_pkg::PH_FAIL && uri_phase != usv_pkg::PH_SCHEME && esc_left == 0;
        if (ok && uri_phase == usv_pkg::PH_HOST)
            ok = host_acceptable();
        verdict.uri_valid      = ok;
        verdict.bracketed_host = ok && host_st.opens_bracket;
        expected_verdicts.insert(expected_verdicts.size(), verdict);
        uri_clear();
    endfunction

    // verdict checker
    always @(posedge i_clk) begin
        usv_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_verdicts.size() == 0) begin
                $error("unexpected verdict transfer: uri_valid %0b bracketed_host %0b",
                       o_out_data.uri_valid, o_out_data.bracketed_host);
                error_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (o_out_data.uri_valid !== want.uri_valid) begin
                    $error("uri_valid mismatch: expected %0b, actual %0b",
                           want.uri_valid, o_out_data.uri_valid);
                    error_count++;
                end
                if (o_out_data.bracketed_host !== want.bracketed_host) begin
                    $error("bracketed_host mismatch: expected %0b, actual %0b",
                           want.bracketed_host, o_out_data.bracketed_host);
                    error_count++;
                end
            end
        end
    end

    // one byte transfer, with random gaps ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        usv_pkg::t_in_item item;
        item.char_byte = b;
        item.last_byte = last;
        if (!quiet_mode) begin
            while ($urandom_range(99) < 9) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predict_byte(b, last);
    endtask

    task automatic send_uri(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < uri_buf.size(); i++)
            send_byte(uri_buf[i], i == uri_buf.size() - 1);
    endtask

    // hold off until every verdict is back and the block has settled
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_port_limit(input logic [15:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        port_limit = value;
    endtask

    // random uri builder
    function automatic void add_byte(input logic [7:0] b);
        uri_buf.insert(uri_buf.size(), b);
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void put_from(input string set, input int count);
        for (int i = 0; i < count; i++)
            add_byte(set[$urandom_range(set.len() - 1)]);
    endfunction

    function automatic void put_escape();
        add_byte("%");
        put_from(HEX_SET, 1);
        // mostly good escapes, some with a bad second digit
        if ($urandom_range(4) == 0)
            add_byte(8'($urandom_range(1, 255)));
        else
            put_from(HEX_SET, 1);
    endfunction

    function automatic void put_segment();
        int count;
        int sel;
        count = $urandom_range(0, 6);
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 80)
                put_from(SEGMENT_SET, 1);
            else if (sel < 88)
                put_escape();
            else if (sel < 94)
                put_from("?#", 1);
            else
                add_byte(8'($urandom_range(1, 255)));
        end
    endfunction

    function automatic void put_port();
        int unsigned sel;
        int unsigned num;
        sel = $urandom_range(99);
        if (sel < 10)
            return;
        else if (sel < 30)
            num = int'(port_limit);
        else if (sel < 50)
            num = int'(port_limit) + 1;
        else if (sel < 80)
            num = $urandom_range(0, 65535);
        else if (sel < 90)
            num = $urandom_range(65536, 999999999);
        else begin
            put_str("00");
            num = $urandom_range(0, 999);
        end
        put_str($sformatf("%0d", num));
    endfunction

    function automatic void build_random_uri();
        int kind;
        kind = $urandom_range(99);
        uri_buf.delete();
        // pure noise
        if (kind < 8) begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(1, 255)));
            return;
        end
        put_from(SCHEME_SET, (kind < 11) ? 0 : $urandom_range(1, 4));
        if ($urandom_range(19) != 0)
            put_str(":");
        // authority
        if ($urandom_range(9) < 6) begin
            put_str("//");
            if ($urandom_range(3) == 0) begin
                put_from(USERINFO_SET, $urandom_range(0, 4));
                put_str("@");
            end
            if ($urandom_range(4) == 0) begin
                put_str("[");
                put_from(IPV6_SET, $urandom_range(0, 6));
                if ($urandom_range(7) != 0)
                    put_str("]");
            end else begin
                put_from(HOST_SET, $urandom_range(0, 5));
                if ($urandom_range(9) == 0)
                    put_escape();
            end
            if ($urandom_range(1) == 1) begin
                put_str(":");
                put_port();
            end
        end
        if ($urandom_range(1) == 1) begin
            put_str("/");
            put_segment();
        end
        if ($urandom_range(2) == 0) begin
            put_str("?");
            put_segment();
        end
        if ($urandom_range(3) == 0) begin
            put_str("#");
            put_segment();
        end
        // occasional single-byte corruption
        if ($urandom_range(9) == 0 && uri_buf.size() != 0)
            uri_buf[$urandom_range(uri_buf.size() - 1)] = 8'($urandom_range(1, 255));
        if (uri_buf.size() == 0)
            put_str("x");
    endfunction

    // scheme: empty, missing colon, bad characters, high bytes
    task automatic test_scheme_rules();
        send_uri("a:");
        send_uri("abc");
        send_uri(":x");
        send_uri("+.-9Z:");
        send_uri("a b:x");
        send_uri("\377:");
        send_uri("A:\200\001");
    endtask

    // authority: userinfo, ports, brackets, host escapes
    task automatic test_authority();
        send_uri("h://u:p@h:65535/");
        send_uri("h://host:65536");
        send_uri("h://h:99999999");
        send_uri("h://h:");
        send_uri("h://u@v@h");
        send_uri("h://[::1]:8080/x");
        send_uri("h://[::1");
        send_uri("h://%41b.c/");
        send_uri("h://a:b:c");
        send_uri("h://[v1]");
    endtask

    // path, query and fragment classes and escapes
    task automatic test_segments();
        send_uri("h:/a%2Fb?c/?#f");
        send_uri("h:/a%G1");
        send_uri("h:/a%2");
        send_uri("h:/a%/2");
        send_uri("h:x#a#b");
        send_uri("h:/\177");
    endtask

    // port limit at both extremes and in between
    task automatic test_port_limit();
        write_port_limit(LIMIT_MIN);
        send_uri("h://h:0");
        send_uri("h://h:1");
        send_uri("h://h");
        write_port_limit(16'd1234);
        send_uri("h://h:1234");
        send_uri("h://h:1235/");
        write_port_limit(LIMIT_MAX);
        send_uri("h://h:65535");
    endtask

    // random uris under several port limits
    task automatic test_random_uris();
        logic [15:0] limits[4];
        int          sent;
        limits = '{LIMIT_MAX, LIMIT_MIN, 16'($urandom_range(1, 65534)), 16'd80};
        foreach (limits[p]) begin
            write_port_limit(limits[p]);
            // one whole phase runs with no idling on either side
            quiet_mode = (p == 2);
            sent = 0;
            while (sent < RANDOM_BYTES / 4) begin
                build_random_uri();
                sent += uri_buf.size();
                send_buffer();
                // in the first phase only, the sender holds off once mid-phase until all verdicts are in
                if (p == 0 && sent >= RANDOM_BYTES / 8 && sent - uri_buf.size() < RANDOM_BYTES / 8)
                    wait_drained();
            end
            quiet_mode = 1'b0;
        end
    endtask

    initial begin
        port_limit = LIMIT_MAX;
        uri_clear();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_port_limit(LIMIT_MAX);
        test_scheme_rules();
        test_authority();
        test_segments();
        test_port_limit();
        test_random_uris();

        wait_drained();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
